// File: hw/rtl/utf8_line_column_tracker_assert.svh
// Assertion macros shared by the position tracker modules.
`ifndef UTF8_LINE_COLUMN_TRACKER_ASSERT_SVH
`define UTF8_LINE_COLUMN_TRACKER_ASSERT_SVH

// Plain implication or invariant, sampled on clk_i, off while in reset.
`define U8LC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define U8LC_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hw/rtl/u8lc_pkg.sv
// Types and constants of the UTF-8 line and column tracker.
package u8lc_pkg;

  // Byte class decided by the front end.
  typedef enum logic [2:0] {
    KIND_EOT,
    KIND_NEWLINE,
    KIND_ASCII,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4,
    KIND_CONT,
    KIND_INVALID
  } kind_e;

  // One queued item: class plus the payload bits of a lead or continuation byte.
  typedef struct packed {
    kind_e      kind;
    logic [5:0] bits;
  } entry_t;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] ASCII_LIMIT  = 8'h80;
  localparam logic [7:0] MASK_C0      = 8'hC0;
  localparam logic [7:0] MASK_E0      = 8'hE0;
  localparam logic [7:0] MASK_F0      = 8'hF0;
  localparam logic [7:0] MASK_F8      = 8'hF8;
  localparam logic [7:0] CONT_VAL     = 8'h80;
  localparam logic [7:0] LEAD2_VAL    = 8'hC0;
  localparam logic [7:0] LEAD3_VAL    = 8'hE0;
  localparam logic [7:0] LEAD4_VAL    = 8'hF0;
  localparam logic [7:0] CONT_BITS    = 8'h3F;
  localparam logic [7:0] LEAD2_BITS   = 8'h1F;
  localparam logic [7:0] LEAD3_BITS   = 8'h0F;
  localparam logic [7:0] LEAD4_BITS   = 8'h07;

  localparam int unsigned     CP_W          = 21;
  localparam logic [CP_W-1:0] SUPPLEMENTARY = 21'h10000;

endpackage

// File: hw/rtl/u8lc_front.sv
// Front end: accepts input items and classifies each byte.
module u8lc_front (
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [7:0]           s_tdata_i,
  input  logic                 s_tlast_i,
  input  logic                 full_i,
  output logic                 push_o,
  output u8lc_pkg::entry_t     entry_o
);

  logic [7:0] masked;

  assign s_tready_o = !full_i;
  assign push_o     = s_tvalid_i && !full_i;

  always_comb begin
    masked        = 8'h00;
    entry_o.kind  = u8lc_pkg::KIND_INVALID;
    if (s_tlast_i) begin
      entry_o.kind = u8lc_pkg::KIND_EOT;
    end else if (s_tdata_i == u8lc_pkg::NEWLINE_BYTE) begin
      entry_o.kind = u8lc_pkg::KIND_NEWLINE;
    end else if (s_tdata_i < u8lc_pkg::ASCII_LIMIT) begin
      entry_o.kind = u8lc_pkg::KIND_ASCII;
    end else if ((s_tdata_i & u8lc_pkg::MASK_C0) == u8lc_pkg::CONT_VAL) begin
      entry_o.kind = u8lc_pkg::KIND_CONT;
      masked       = s_tdata_i & u8lc_pkg::CONT_BITS;
    end else if ((s_tdata_i & u8lc_pkg::MASK_E0) == u8lc_pkg::LEAD2_VAL) begin
      entry_o.kind = u8lc_pkg::KIND_LEAD2;
      masked       = s_tdata_i & u8lc_pkg::LEAD2_BITS;
    end else if ((s_tdata_i & u8lc_pkg::MASK_F0) == u8lc_pkg::LEAD3_VAL) begin
      entry_o.kind = u8lc_pkg::KIND_LEAD3;
      masked       = s_tdata_i & u8lc_pkg::LEAD3_BITS;
    end else if ((s_tdata_i & u8lc_pkg::MASK_F8) == u8lc_pkg::LEAD4_VAL) begin
      entry_o.kind = u8lc_pkg::KIND_LEAD4;
      masked       = s_tdata_i & u8lc_pkg::LEAD4_BITS;
    end
    entry_o.bits = masked[5:0];
  end

endmodule

// File: hw/rtl/u8lc_queue.sv
// Short queue of classified items between front and back end.
`include "utf8_line_column_tracker_assert.svh"

module u8lc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  u8lc_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output u8lc_pkg::entry_t entry_o
);

  localparam int unsigned CNT_W = u8lc_pkg::QUEUE_PTR_W + 1;

  u8lc_pkg::entry_t                   mem_q [u8lc_pkg::QUEUE_DEPTH];
  logic [u8lc_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [u8lc_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]                   count_q, count_d;

  assign full_o  = (count_q == CNT_W'(u8lc_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == u8lc_pkg::QUEUE_PTR_W'(u8lc_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == u8lc_pkg::QUEUE_PTR_W'(u8lc_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `U8LC_ASSERT(a_count_bound, count_q <= CNT_W'(u8lc_pkg::QUEUE_DEPTH), "queue overfilled")
  `U8LC_ASSERT(a_pop_nonempty, pop_i |-> count_q != '0, "pop from empty queue")
  `U8LC_ASSERT(a_full_no_push, full_o |-> !push_i, "push into full queue")

endmodule

// File: hw/rtl/u8lc_back.sv
// Back end: position counters, UTF-8 sequence tracking and result register.
`include "utf8_line_column_tracker_assert.svh"

module u8lc_back #(
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned LINE_BITS   = 24,
  parameter int unsigned COLUMN_BITS = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  input  u8lc_pkg::entry_t       entry_i,
  output logic                   pop_o,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [OFFSET_BITS-1:0] offset_o,
  output logic [LINE_BITS-1:0]   line_o,
  output logic [COLUMN_BITS-1:0] col_cp_o,
  output logic [COLUMN_BITS-1:0] col_u16_o
);

  localparam int unsigned CP_W = u8lc_pkg::CP_W;
  localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

  logic [OFFSET_BITS-1:0] bytes_q, bytes_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] done_cp_q, done_cp_d;
  logic [COLUMN_BITS-1:0] done_u16_q, done_u16_d;
  logic [1:0]             rem_q, rem_d;
  logic                   four_q, four_d;
  logic [CP_W-1:0]        partial_q, partial_d;

  logic                   out_valid_q;
  logic [OFFSET_BITS-1:0] out_offset_q;
  logic [LINE_BITS-1:0]   out_line_q;
  logic [COLUMN_BITS-1:0] out_cp_q, out_u16_q;

  logic                   pend;
  logic [COLUMN_BITS+1:0] rep_cp_sum, rep_u16_sum;
  logic [COLUMN_BITS-1:0] rep_cp, rep_u16;
  logic [1:0]             cp_inc, u16_inc;
  logic [COLUMN_BITS:0]   cp_sum, u16_sum;
  logic [CP_W-1:0]        shifted;
  logic [OFFSET_BITS-1:0] bytes_inc;
  logic [LINE_BITS-1:0]   line_inc;

  assign pop_o = !empty_i && (!out_valid_q || m_tready_i);

  // Reported columns: 1 + finished units + 1 for a pending sequence, saturating.
  assign pend        = (rem_q != 2'd0);
  assign rep_cp_sum  = (COLUMN_BITS+2)'(done_cp_q) + (COLUMN_BITS+2)'(1)
                       + (COLUMN_BITS+2)'(pend);
  assign rep_u16_sum = (COLUMN_BITS+2)'(done_u16_q) + (COLUMN_BITS+2)'(1)
                       + (COLUMN_BITS+2)'(pend);
  assign rep_cp  = (rep_cp_sum > (COLUMN_BITS+2)'(COL_MAX)) ? COL_MAX
                                                             : rep_cp_sum[COLUMN_BITS-1:0];
  assign rep_u16 = (rep_u16_sum > (COLUMN_BITS+2)'(COL_MAX)) ? COL_MAX
                                                              : rep_u16_sum[COLUMN_BITS-1:0];

  assign bytes_inc = (bytes_q == {OFFSET_BITS{1'b1}}) ? bytes_q : bytes_q + 1'b1;
  assign line_inc  = (line_q == {LINE_BITS{1'b1}}) ? line_q : line_q + 1'b1;
  assign shifted   = {partial_q[CP_W-7:0], entry_i.bits};

  always_comb begin
    bytes_d    = bytes_q;
    line_d     = line_q;
    done_cp_d  = done_cp_q;
    done_u16_d = done_u16_q;
    rem_d      = rem_q;
    four_d     = four_q;
    partial_d  = partial_q;
    cp_inc     = 2'd0;
    u16_inc    = 2'd0;
    cp_sum     = '0;
    u16_sum    = '0;
    if (pop_o) begin
      case (entry_i.kind)
        u8lc_pkg::KIND_EOT: begin
          bytes_d    = '0;
          line_d     = LINE_BITS'(1);
          done_cp_d  = '0;
          done_u16_d = '0;
          rem_d      = 2'd0;
          four_d     = 1'b0;
          partial_d  = '0;
        end
        u8lc_pkg::KIND_NEWLINE: begin
          bytes_d    = bytes_inc;
          line_d     = line_inc;
          done_cp_d  = '0;
          done_u16_d = '0;
          rem_d      = 2'd0;
          four_d     = 1'b0;
          partial_d  = '0;
        end
        default: begin
          bytes_d = bytes_inc;
          if (pend && entry_i.kind == u8lc_pkg::KIND_CONT) begin
            partial_d = shifted;
            rem_d     = rem_q - 2'd1;
            if (rem_q == 2'd1) begin
              cp_inc    = 2'd1;
              u16_inc   = (four_q && shifted >= u8lc_pkg::SUPPLEMENTARY) ? 2'd2 : 2'd1;
              four_d    = 1'b0;
              partial_d = '0;
            end
          end else begin
            // a pending sequence cut short counts as one character
            cp_inc    = {1'b0, pend};
            rem_d     = 2'd0;
            four_d    = 1'b0;
            partial_d = '0;
            if (entry_i.kind == u8lc_pkg::KIND_LEAD2) begin
              rem_d     = 2'd1;
              partial_d = CP_W'(entry_i.bits);
            end else if (entry_i.kind == u8lc_pkg::KIND_LEAD3) begin
              rem_d     = 2'd2;
              partial_d = CP_W'(entry_i.bits);
            end else if (entry_i.kind == u8lc_pkg::KIND_LEAD4) begin
              rem_d     = 2'd3;
              four_d    = 1'b1;
              partial_d = CP_W'(entry_i.bits);
            end else begin
              cp_inc = cp_inc + 2'd1;
            end
            u16_inc = cp_inc;
          end
          cp_sum     = (COLUMN_BITS+1)'(done_cp_q) + (COLUMN_BITS+1)'(cp_inc);
          u16_sum    = (COLUMN_BITS+1)'(done_u16_q) + (COLUMN_BITS+1)'(u16_inc);
          done_cp_d  = cp_sum[COLUMN_BITS] ? COL_MAX : cp_sum[COLUMN_BITS-1:0];
          done_u16_d = u16_sum[COLUMN_BITS] ? COL_MAX : u16_sum[COLUMN_BITS-1:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q     <= '0;
      line_q      <= LINE_BITS'(1);
      done_cp_q   <= '0;
      done_u16_q  <= '0;
      rem_q       <= 2'd0;
      four_q      <= 1'b0;
      partial_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bytes_q    <= bytes_d;
      line_q     <= line_d;
      done_cp_q  <= done_cp_d;
      done_u16_q <= done_u16_d;
      rem_q      <= rem_d;
      four_q     <= four_d;
      partial_q  <= partial_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_offset_q <= bytes_q;
      out_line_q   <= line_q;
      out_cp_q     <= rep_cp;
      out_u16_q    <= rep_u16;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign offset_o   = out_offset_q;
  assign line_o     = out_line_q;
  assign col_cp_o   = out_cp_q;
  assign col_u16_o  = out_u16_q;

  `U8LC_ASSERT(a_idle_clean, rem_q == 2'd0 |-> partial_q == '0 && !four_q,
               "sequence state left over with no sequence pending")
  `U8LC_ASSERT_NEXT(a_eot_clears, pop_o && entry_i.kind == u8lc_pkg::KIND_EOT,
                    bytes_q == '0 && line_q == LINE_BITS'(1) && done_cp_q == '0,
                    "end of text did not clear the counters")
  `U8LC_ASSERT(a_line_nonzero, line_q != '0, "line counter reached zero")

endmodule

// File: hw/rtl/utf8_line_column_tracker.sv
// Top level of the UTF-8 line and column position tracker.
//
//   channel   dir  payload (low bit up)                      marks
//   s_axis    in   tdata: data_byte[7:0]                     tlast: end_of_text
//   m_axis    out  tdata: offset, line, col_codepoints,      -
//                         col_u16, zero pad to bytes
//
// One item per cycle sustained while m_axis does not stall; a result is valid at
// m_axis once its item has passed the queue write and then the counter update into
// the result register. The counter update in the back end is the loop that sets
// the rate: one item a cycle. Reset clears the queue and all counters at once, no
// clearing pass. A stall at m_axis holds the result register; the queue fills and
// then s_axis tready drops.
module utf8_line_column_tracker #(
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned LINE_BITS   = 24,
  parameter int unsigned COLUMN_BITS = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,  // data_byte
  input  logic               s_axis_tlast,  // end_of_text
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // offset, line, col_codepoints, col_u16, zero pad
  output logic [((OFFSET_BITS+LINE_BITS+2*COLUMN_BITS+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned OUT_W  = OFFSET_BITS + LINE_BITS + 2 * COLUMN_BITS;
  localparam int unsigned DATA_W = ((OUT_W + 7) / 8) * 8;

  logic                   push, pop, full, empty;
  u8lc_pkg::entry_t       wr_entry, rd_entry;
  logic [OFFSET_BITS-1:0] offset;
  logic [LINE_BITS-1:0]   line;
  logic [COLUMN_BITS-1:0] col_cp, col_u16;

  u8lc_front u_front (
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (wr_entry)
  );

  u8lc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (wr_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (rd_entry)
  );

  u8lc_back #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .entry_i    (rd_entry),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .offset_o   (offset),
    .line_o     (line),
    .col_cp_o   (col_cp),
    .col_u16_o  (col_u16)
  );

  assign m_axis_tdata = DATA_W'({col_u16, col_cp, line, offset});

endmodule

// File: test/testbench.sv
// Self-checking testbench for the UTF-8 line and column position tracker.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned LINE_W   = 24;
  localparam int unsigned COL_W    = 20;
  localparam int unsigned CP_W     = u8lc_pkg::CP_W;
  localparam int unsigned RESULT_W = ((OFFSET_W + LINE_W + 2*COL_W + 7) / 8) * 8;
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic [COL_W-1:0]    col_u16;
    logic [COL_W-1:0]    col_codepoints;
    logic [LINE_W-1:0]   line;
    logic [OFFSET_W-1:0] offset;
  } position_t;

  // Expected positions, worked out from every accepted byte.
  class position_scoreboard;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;
    localparam logic [LINE_W-1:0]   LINE_MAX   = '1;
    localparam logic [COL_W-1:0]    COL_MAX    = '1;

    logic [OFFSET_W-1:0] next_offset;
    logic [LINE_W-1:0]   line_no;
    logic [COL_W-1:0]    codepoints;
    logic [COL_W-1:0]    utf16_units;
    logic [1:0]          cont_left;
    logic                quad_seq;
    logic [CP_W-1:0]     cp_acc;
    position_t           expected_positions[$];
    int                  mismatches;

    function new();
      mismatches = 0;
      clear_text();
    endfunction

    function void clear_text();
      next_offset = '0;
      line_no     = LINE_W'(1);
      codepoints  = '0;
      utf16_units = '0;
      close_seq();
    endfunction

    function void close_seq();
      cont_left = '0;
      quad_seq  = 1'b0;
      cp_acc    = '0;
    endfunction

    function logic [COL_W-1:0] report_col(logic [COL_W-1:0] done, logic pend);
      logic [COL_W+1:0] sum;
      sum = {2'b00, done} + (COL_W+2)'(1) + (COL_W+2)'(pend);
      return (sum > {2'b00, COL_MAX}) ? COL_MAX : sum[COL_W-1:0];
    endfunction

    function void count_char(int unsigned units);
      logic [COL_W+1:0] sum;
      if (codepoints != COL_MAX) codepoints = codepoints + 1'b1;
      sum = {2'b00, utf16_units} + (COL_W+2)'(units);
      utf16_units = (sum > {2'b00, COL_MAX}) ? COL_MAX : sum[COL_W-1:0];
    endfunction

    function void note_byte(logic [7:0] b, logic eot);
      position_t p;
      logic      pend;
      pend = (cont_left != 2'd0);
      p.offset         = next_offset;
      p.line           = line_no;
      p.col_codepoints = report_col(codepoints, pend);
      p.col_u16        = report_col(utf16_units, pend);
      expected_positions.insert(expected_positions.size(), p);

      if (eot) begin
        clear_text();
        return;
      end
      if (next_offset != OFFSET_MAX) next_offset = next_offset + 1'b1;

      if (b == u8lc_pkg::NEWLINE_BYTE) begin
        if (line_no != LINE_MAX) line_no = line_no + 1'b1;
        codepoints  = '0;
        utf16_units = '0;
        close_seq();
        return;
      end

      if (cont_left != 2'd0) begin
        if ((b & u8lc_pkg::MASK_C0) == u8lc_pkg::CONT_VAL) begin
          cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
          cont_left = cont_left - 2'd1;
          if (cont_left == 2'd0) begin
            count_char((quad_seq && cp_acc >= u8lc_pkg::SUPPLEMENTARY) ? 2 : 1);
            close_seq();
          end
          return;
        end
        // a non-continuation byte cuts the sequence short
        count_char(1);
        close_seq();
      end

      if (b < u8lc_pkg::ASCII_LIMIT) begin
        count_char(1);
      end else if ((b & u8lc_pkg::MASK_E0) == u8lc_pkg::LEAD2_VAL) begin
        cont_left = 2'd1;
        cp_acc    = CP_W'(b & u8lc_pkg::LEAD2_BITS);
        quad_seq  = 1'b0;
      end else if ((b & u8lc_pkg::MASK_F0) == u8lc_pkg::LEAD3_VAL) begin
        cont_left = 2'd2;
        cp_acc    = CP_W'(b & u8lc_pkg::LEAD3_BITS);
        quad_seq  = 1'b0;
      end else if ((b & u8lc_pkg::MASK_F8) == u8lc_pkg::LEAD4_VAL) begin
        cont_left = 2'd3;
        cp_acc    = CP_W'(b & u8lc_pkg::LEAD4_BITS);
        quad_seq  = 1'b1;
      end else begin
        // stray continuation or invalid lead
        count_char(1);
      end
    endfunction

    function void check_position(logic [RESULT_W-1:0] data);
      position_t got;
      position_t want;
      got = data[OFFSET_W+LINE_W+2*COL_W-1:0];
      if (expected_positions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: offset=%0d line=%0d cp=%0d u16=%0d",
                   got.offset, got.line, got.col_codepoints, got.col_u16);
        return;
      end
      want = expected_positions.pop_front();
      if (got.offset !== want.offset || got.line !== want.line ||
          got.col_codepoints !== want.col_codepoints || got.col_u16 !== want.col_u16) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected offset=%0d line=%0d cp=%0d u16=%0d, ",
                    "got offset=%0d line=%0d cp=%0d u16=%0d"},
                   want.offset, want.line, want.col_codepoints, want.col_u16,
                   got.offset, got.line, got.col_codepoints, got.col_u16);
      end
    endfunction

    function int pending();
      return expected_positions.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [RESULT_W-1:0] m_axis_tdata;

  position_scoreboard board = new();
  bit                 no_idle = 1'b0;
  int unsigned        items_sent = 0;
  int unsigned        cycles = 0;
  int                 stall_left = 0;

  utf8_line_column_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: check on handshake, then pick next tready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_position(m_axis_tdata);
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = gap_len();
    end
  end

  task automatic push_item(input logic [7:0] b, input logic eot);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_byte(b, eot);
    items_sent++;
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // one character, mostly well-formed UTF-8 with random payload
  task automatic send_random_char();
    int pick;
    int conts;
    int need;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      push_item(8'($urandom_range(0, 127)), 1'b0);
    end else if (pick < 38) begin
      push_item(u8lc_pkg::NEWLINE_BYTE, 1'b0);
    end else if (pick < 52) begin
      push_item(u8lc_pkg::LEAD2_VAL | 8'($urandom_range(0, 31)), 1'b0);
      push_item(cont_byte(), 1'b0);
    end else if (pick < 66) begin
      push_item(u8lc_pkg::LEAD3_VAL | 8'($urandom_range(0, 15)), 1'b0);
      repeat (2) push_item(cont_byte(), 1'b0);
    end else if (pick < 80) begin
      push_item(u8lc_pkg::LEAD4_VAL | 8'($urandom_range(0, 7)), 1'b0);
      repeat (3) push_item(cont_byte(), 1'b0);
    end else if (pick < 82) begin
      push_item(8'($urandom), 1'b1);
    end else if (pick < 92) begin
      push_item(8'($urandom), 1'b0);
    end else begin
      // truncated sequence closed by a non-continuation byte
      need = $urandom_range(1, 3);
      case (need)
        1: push_item(u8lc_pkg::LEAD2_VAL | 8'($urandom_range(0, 31)), 1'b0);
        2: push_item(u8lc_pkg::LEAD3_VAL | 8'($urandom_range(0, 15)), 1'b0);
        default: push_item(u8lc_pkg::LEAD4_VAL | 8'($urandom_range(0, 7)), 1'b0);
      endcase
      conts = $urandom_range(0, need - 1);
      repeat (conts) push_item(cont_byte(), 1'b0);
      if ($urandom_range(0, 1) == 0) push_item(8'($urandom_range(0, 127)), 1'b0);
      else push_item(8'($urandom_range(8'hC0, 8'hFF)), 1'b0);
    end
  endtask

  initial begin
    int unsigned random_end;
    int unsigned next_switch;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ASCII extremes and a newline
    push_item(8'h00, 1'b0);
    push_item(8'h7F, 1'b0);
    push_item(8'h0A, 1'b0);
    // two, three and four byte sequences; the last one above 0xFFFF
    push_item(8'hC3, 1'b0); push_item(8'hA9, 1'b0);
    push_item(8'hE2, 1'b0); push_item(8'h82, 1'b0); push_item(8'hAC, 1'b0);
    push_item(8'hF0, 1'b0); push_item(8'h9F, 1'b0); push_item(8'h98, 1'b0);
    push_item(8'h80, 1'b0);
    // overlong four byte form stays one UTF-16 unit
    push_item(8'hF0, 1'b0); push_item(8'h80, 1'b0); push_item(8'h80, 1'b0);
    push_item(8'h80, 1'b0);
    // sequence cut short, then newline inside a sequence
    push_item(8'hC3, 1'b0); push_item(8'h41, 1'b0);
    push_item(8'hE2, 1'b0); push_item(8'h0A, 1'b0);
    // stray continuation and invalid leads
    push_item(8'h80, 1'b0);
    push_item(8'hF8, 1'b0);
    push_item(8'hFF, 1'b0);
    // out-of-range lead still opens a sequence
    push_item(8'hF7, 1'b0); push_item(8'hBF, 1'b0); push_item(8'hBF, 1'b0);
    push_item(8'hBF, 1'b0);
    // end of text with a sequence pending, then straight after reset state
    push_item(8'hF4, 1'b0);
    push_item(8'hFF, 1'b1);
    push_item(8'h00, 1'b1);

    random_end  = items_sent + RANDOM_ITEMS;
    next_switch = items_sent;
    while (items_sent < random_end) begin
      if (items_sent >= next_switch) begin
        no_idle     = ($urandom_range(0, 3) == 0);
        next_switch = next_switch + 150;
      end
      send_random_char();
    end
    s_axis_tvalid <= 1'b0;
    no_idle = 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
